>>> hw/rtl/dwmr_pkg.sv
// Shared constants, codes and types of the deque with max removal.
package dwmr_pkg;

  // Ring store geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths fixed by the channel format
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  // Operation codes on the request channel
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_MAX   = 3'd4;
  localparam logic [OP_W-1:0] OP_SWAP_ENDS = 3'd5;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_PUSH_HEAD,
    CMD_PUSH_TAIL,
    CMD_POP_HEAD,
    CMD_POP_TAIL,
    CMD_REM_MAX,
    CMD_SWAP_ENDS,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic signed [DATA_W-1:0]  data;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP_RD,
    BK_SWAP_WR_HEAD,
    BK_SWAP_WR_TAIL,
    BK_SCAN,
    BK_SHIFT,
    BK_MAX_DONE
  } bk_state_t;

endpackage

>>> hw/rtl/dwmr_if.sv
// Request and response channel interfaces of the deque with max removal.
interface dwmr_in_if import dwmr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, output op, output data_value, input ready);
  modport sink   (input valid, input op, input data_value, output ready);
endinterface

interface dwmr_out_if import dwmr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [OCC_W-1:0]         occupancy;
  logic signed [DATA_W-1:0] removed_value;

  modport source (output valid, output status, output occupancy, output removed_value,
                  input ready);
  modport sink   (input valid, input status, input occupancy, input removed_value,
                  output ready);
endinterface

>>> hw/rtl/dwmr_front.sv
// Front end: accept requests and classify the op code into a command.
module dwmr_front import dwmr_pkg::*; (
  dwmr_in_if.sink in_req,
  output logic    push_valid,
  input  logic    push_ready,
  output cmd_t    push_cmd
);

  cmd_kind_t kind;

  always_comb begin
    unique case (in_req.op)
      OP_PUSH_HEAD: kind = CMD_PUSH_HEAD;
      OP_POP_TAIL:  kind = CMD_POP_TAIL;
      OP_PUSH_TAIL: kind = CMD_PUSH_TAIL;
      OP_POP_HEAD:  kind = CMD_POP_HEAD;
      OP_REM_MAX:   kind = CMD_REM_MAX;
      OP_SWAP_ENDS: kind = CMD_SWAP_ENDS;
      default:      kind = CMD_NOP;
    endcase
  end

  assign push_valid    = in_req.valid;
  assign in_req.ready  = push_ready;
  assign push_cmd.kind = kind;
  assign push_cmd.data = in_req.data_value;

endmodule

>>> hw/rtl/dwmr_cmd_fifo.sv
// Short command queue decoupling the front end from the execution back end.
module dwmr_cmd_fifo import dwmr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int QPTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t              entry_r [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/dwmr_back.sv
// Back end: ring store, head and count, sequencer for each command, result register.
module dwmr_back import dwmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  dwmr_out_if.source  out_rsp
);

  localparam int SUM_W = CNT_W + 1;

  // Ring position of the element pos places behind the head
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(pos);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  // Occupancy field keeps the low bits of the count
  function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCC_W-1:0] wide;
    wide = {{OCC_W{1'b0}}, cnt};
    return wide[OCC_W-1:0];
  endfunction

  bk_state_t state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] best_pos_r, best_pos_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]          out_status_r, out_status_nxt;
  logic [OCC_W-1:0]         out_occ_r, out_occ_nxt;
  logic signed [DATA_W-1:0] out_removed_r, out_removed_nxt;

  // Element store
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic                     wr_en, rd_en;
  logic [IDX_W-1:0]         wr_addr, rd_a_addr, rd_b_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;

  logic                     out_free;
  logic                     full, empty;
  logic [IDX_W-1:0]         head_dec, head_inc, tail_addr;
  logic [CNT_W-1:0]         last_pos;
  logic                     emit;
  status_t                  emit_status;
  logic [CNT_W-1:0]         emit_cnt;
  logic signed [DATA_W-1:0] emit_removed;
  logic                     take;
  logic [CNT_W-1:0]         scan_bp;

  assign out_free  = !out_valid_r || out_rsp.ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign last_pos  = count_r - CNT_W'(1);
  assign head_dec  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - IDX_W'(1);
  assign head_inc  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
  assign tail_addr = slot_of(head_r, last_pos);
  assign cmd_ready = (state_r == BK_IDLE) && out_free;

  // Scan compare: strict greater, so the earliest maximum stays
  assign take    = (pos_r == '0) || (rd_a_r > best_val_r);
  assign scan_bp = take ? pos_r : best_pos_r;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    best_pos_nxt    = best_pos_r;
    best_val_nxt    = best_val_r;
    wr_en           = 1'b0;
    wr_addr         = head_r;
    wr_data         = cmd.data;
    rd_en           = 1'b0;
    rd_a_addr       = head_r;
    rd_b_addr       = tail_addr;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_cnt        = count_r;
    emit_removed    = '0;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_occ_nxt     = out_occ_r;
    out_removed_nxt = out_removed_r;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          unique case (cmd.kind) inside
            CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
              emit = 1'b1;
              if (full) begin
                emit_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                emit_cnt  = count_r + CNT_W'(1);
                if (cmd.kind == CMD_PUSH_HEAD) begin
                  wr_addr  = head_dec;
                  head_nxt = head_dec;
                end else begin
                  wr_addr = slot_of(head_r, count_r);
                end
              end
            end
            CMD_POP_HEAD, CMD_POP_TAIL, CMD_REM_MAX, CMD_SWAP_ENDS: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else if (cmd.kind == CMD_POP_HEAD) begin
                rd_en     = 1'b1;
                rd_a_addr = head_r;
                head_nxt  = head_inc;
                count_nxt = last_pos;
                state_nxt = BK_POP_RD;
              end else if (cmd.kind == CMD_POP_TAIL) begin
                rd_en     = 1'b1;
                rd_a_addr = tail_addr;
                count_nxt = last_pos;
                state_nxt = BK_POP_RD;
              end else if (cmd.kind == CMD_REM_MAX) begin
                rd_en     = 1'b1;
                rd_a_addr = head_r;
                pos_nxt   = '0;
                state_nxt = BK_SCAN;
              end else if (count_r == CNT_W'(1)) begin
                // swap of a single element changes nothing
                emit = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_a_addr = head_r;
                rd_b_addr = tail_addr;
                state_nxt = BK_SWAP_WR_HEAD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_POP_RD: begin
        if (out_free) begin
          emit         = 1'b1;
          emit_removed = rd_a_r;
          state_nxt    = BK_IDLE;
        end
      end
      BK_SWAP_WR_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = rd_b_r;
        state_nxt = BK_SWAP_WR_TAIL;
      end
      BK_SWAP_WR_TAIL: begin
        if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = tail_addr;
          wr_data   = rd_a_r;
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_SCAN: begin
        best_pos_nxt = scan_bp;
        best_val_nxt = take ? rd_a_r : best_val_r;
        if (pos_r == last_pos) begin
          if (scan_bp == last_pos) begin
            state_nxt = BK_MAX_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_a_addr = slot_of(head_r, scan_bp + CNT_W'(1));
            pos_nxt   = scan_bp;
            state_nxt = BK_SHIFT;
          end
        end else begin
          rd_en     = 1'b1;
          rd_a_addr = slot_of(head_r, pos_r + CNT_W'(1));
          pos_nxt   = pos_r + CNT_W'(1);
        end
      end
      BK_SHIFT: begin
        // close up: element pos+1 moves to pos, next source read in parallel
        wr_en   = 1'b1;
        wr_addr = slot_of(head_r, pos_r);
        wr_data = rd_a_r;
        if (pos_r + CNT_W'(2) == count_r) begin
          state_nxt = BK_MAX_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_a_addr = slot_of(head_r, pos_r + CNT_W'(2));
          pos_nxt   = pos_r + CNT_W'(1);
        end
      end
      BK_MAX_DONE: begin
        if (out_free) begin
          count_nxt    = last_pos;
          emit         = 1'b1;
          emit_cnt     = last_pos;
          emit_removed = best_val_r;
          state_nxt    = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = emit_status;
      out_occ_nxt     = occ_of(emit_cnt);
      out_removed_nxt = emit_removed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    best_pos_r    <= best_pos_nxt;
    best_val_r    <= best_val_nxt;
    out_status_r  <= out_status_nxt;
    out_occ_r     <= out_occ_nxt;
    out_removed_r <= out_removed_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.occupancy     = out_occ_r;
  assign out_rsp.removed_value = out_removed_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above store depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN || state_r == BK_SHIFT) |-> pos_r < count_r)
    else $error("scan or shift position beyond live elements");

  a_best_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN && pos_r != '0) |-> best_pos_r < pos_r)
    else $error("best position not behind scan position");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready && !empty &&
     (cmd.kind == CMD_POP_HEAD || cmd.kind == CMD_POP_TAIL))
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not reduce the count by one");

endmodule

>>> hw/rtl/deque_with_max_removal_top.sv
// Top level of the deque with max removal: front end, command queue and back end.
//
// A bounded double-ended queue of DEPTH signed 32-bit values held in a ring.
// in_req carries one request per handshake (valid and ready both high at a
// rising edge): op and data_value. out_rsp returns exactly one result per
// request, in request order: status, occupancy after the operation and the
// removed value (zero unless a pop or max removal took one out).
// Max removal scans the live elements, one per memory read, to find the
// earliest maximum, then closes up the elements after it one per cycle.
// Throughput: one request per cycle for pushes while out_rsp.ready is high;
// a pop waits for the registered read of the ring store, so the back end
// takes no new command until the popped value is in the output register.
// A two-entry command queue lets in_req keep accepting while the back end
// works or a result waits in the output register.
// Reset (rst_n low, synchronous): the queue empties, head and count clear,
// no result is pending. The store itself is not cleared.
// When out_rsp.ready is low the result holds, the back end pauses, and
// in_req.ready drops once the command queue fills.
module deque_with_max_removal_top import dwmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dwmr_in_if.sink    in_req,
  dwmr_out_if.source out_rsp
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Classify each request into a command
  dwmr_front u_front (
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Hold commands while the back end is busy
  dwmr_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (cmd_valid),
    .pop_ready  (cmd_ready),
    .pop_cmd    (cmd)
  );

  // Carry out each command against the ring store and register the result
  dwmr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_rsp   (out_rsp)
  );

endmodule
